### rtl/kts_pkg.sv
package kts_pkg;

   localparam int LEXEME_CHARS_DEF = 8;
   localparam int TEXT_W           = 64;
   localparam int OBUF_DEPTH       = 4;
   localparam int KEYWORD_COUNT    = 8;

   localparam logic [4:0] KIND_ENDFILE = 5'd0;
   localparam logic [4:0] KIND_ERROR   = 5'd1;
   localparam logic [4:0] KIND_KW0     = 5'd2;
   localparam logic [4:0] KIND_ID      = 5'd10;
   localparam logic [4:0] KIND_NUM     = 5'd11;
   localparam logic [4:0] KIND_ASSIGN  = 5'd12;
   localparam logic [4:0] KIND_PLUS    = 5'd13;
   localparam logic [4:0] KIND_MINUS   = 5'd14;
   localparam logic [4:0] KIND_TIMES   = 5'd15;
   localparam logic [4:0] KIND_OVER    = 5'd16;
   localparam logic [4:0] KIND_LPAREN  = 5'd17;
   localparam logic [4:0] KIND_RPAREN  = 5'd18;
   localparam logic [4:0] KIND_EQ      = 5'd19;
   localparam logic [4:0] KIND_LT      = 5'd20;
   localparam logic [4:0] KIND_SEMI    = 5'd21;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]        token_kind;
      logic [TEXT_W-1:0] lexeme_text;
      logic [3:0]        lexeme_length;
      logic              lexeme_truncated;
      logic              last_of_run;
   } rsp_type;

   // up to two tokens produced by one transaction, a before b
   typedef struct packed {
      logic    a_valid;
      logic    b_valid;
      rsp_type a;
      rsp_type b;
   } push_type;

   // keyword spellings, first character in the lowest byte
   localparam logic [TEXT_W-1:0] KW_TEXT [KEYWORD_COUNT] = '{
      64'h6669,         // if
      64'h6E656874,     // then
      64'h65736C65,     // else
      64'h646E65,       // end
      64'h746165706572, // repeat
      64'h6C69746E75,   // until
      64'h64616572,     // read
      64'h6574697277    // write
   };
   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5
   };

   function automatic logic [4:0] id_kind(input logic [TEXT_W-1:0] text,
                                          input logic [3:0] len,
                                          input logic ovf);
      logic [4:0] kind;
      kind = KIND_ID;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (!ovf && text == KW_TEXT[k] && len == KW_LEN[k]) begin
            kind = KIND_KW0 + 5'(k);
         end
      end
      return kind;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] kind;
      unique case (c)
         8'h2B:   kind = KIND_PLUS;
         8'h2D:   kind = KIND_MINUS;
         8'h2A:   kind = KIND_TIMES;
         8'h2F:   kind = KIND_OVER;
         8'h28:   kind = KIND_LPAREN;
         8'h29:   kind = KIND_RPAREN;
         8'h3D:   kind = KIND_EQ;
         8'h3C:   kind = KIND_LT;
         8'h3B:   kind = KIND_SEMI;
         default: kind = KIND_ERROR;
      endcase
      return kind;
   endfunction

endpackage

### rtl/kts_lexer.sv
module kts_lexer #(
   parameter int LEXEME_CHARS = kts_pkg::LEXEME_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  kts_pkg::req_type  req,
   output kts_pkg::push_type push
);

   localparam int BUF_W = 8 * LEXEME_CHARS;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_COMMENT = 3'd1,
      PH_NUM     = 3'd2,
      PH_ID      = 3'd3,
      PH_COLON   = 3'd4
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [BUF_W-1:0] text_ff, text_in;
   logic [3:0]       count_ff, count_in;
   logic             ovf_ff, ovf_in;

   logic [BUF_W-1:0] saved_text;
   logic             full;
   logic             is_digit, is_letter, is_blank;
   logic             rescan;
   logic [7:0]       c;
   logic [4:0]       word_kind;

   assign c         = req.char_code;
   assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
   assign is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   assign is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
   assign full      = count_ff >= 4'(LEXEME_CHARS);
   assign word_kind = kts_pkg::id_kind(kts_pkg::TEXT_W'(text_ff), count_ff, ovf_ff);

   // buffer with the current character dropped into the next free byte
   always_comb begin
      saved_text = text_ff;
      for (int i = 0; i < LEXEME_CHARS; i++) begin
         if (count_ff == 4'(i)) begin
            saved_text[8*i +: 8] = c;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      text_in  = text_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      rescan   = 1'b0;

      push.a_valid            = 1'b0;
      push.a.token_kind       = word_kind;
      push.a.lexeme_text      = kts_pkg::TEXT_W'(text_ff);
      push.a.lexeme_length    = count_ff;
      push.a.lexeme_truncated = ovf_ff;
      push.b_valid            = 1'b0;
      push.b.token_kind       = kts_pkg::single_kind(c);
      push.b.lexeme_text      = kts_pkg::TEXT_W'(c);
      push.b.lexeme_length    = 4'd1;
      push.b.lexeme_truncated = 1'b0;

      if (req.end_of_input) begin
         unique case (phase_ff)
            PH_NUM: begin
               push.a_valid      = 1'b1;
               push.a.token_kind = kts_pkg::KIND_NUM;
            end
            PH_ID: begin
               push.a_valid = 1'b1;
            end
            PH_COLON: begin
               push.a_valid      = 1'b1;
               push.a.token_kind = kts_pkg::KIND_ERROR;
            end
            default: ;
         endcase
         push.b_valid            = 1'b1;
         push.b.token_kind       = kts_pkg::KIND_ENDFILE;
         push.b.lexeme_text      = '0;
         push.b.lexeme_length    = 4'd0;
         phase_in = PH_START;
         text_in  = '0;
         count_in = 4'd0;
         ovf_in   = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_COMMENT: begin
               if (c == CH_RBRACE) begin
                  phase_in = PH_START;
               end
            end
            PH_NUM, PH_ID: begin
               if ((phase_ff == PH_NUM) ? is_digit : is_letter) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     text_in  = saved_text;
                     count_in = count_ff + 4'd1;
                  end
               end else begin
                  push.a_valid = 1'b1;
                  if (phase_ff == PH_NUM) begin
                     push.a.token_kind = kts_pkg::KIND_NUM;
                  end
                  rescan = 1'b1;
               end
            end
            PH_COLON: begin
               push.a_valid = 1'b1;
               if (c == CH_EQUAL) begin
                  push.a.token_kind    = kts_pkg::KIND_ASSIGN;
                  push.a.lexeme_text   = kts_pkg::TEXT_W'(saved_text);
                  push.a.lexeme_length = count_ff + 4'd1;
                  phase_in = PH_START;
                  text_in  = '0;
                  count_in = 4'd0;
                  ovf_in   = 1'b0;
               end else begin
                  push.a.token_kind = kts_pkg::KIND_ERROR;
                  rescan = 1'b1;
               end
            end
            default: rescan = 1'b1;
         endcase

         // the start state always sees an empty lexeme buffer
         if (rescan) begin
            phase_in = PH_START;
            text_in  = '0;
            count_in = 4'd0;
            ovf_in   = 1'b0;
            priority if (is_blank) begin
            end else if (c == CH_LBRACE) begin
               phase_in = PH_COMMENT;
            end else if (is_digit || is_letter || c == CH_COLON) begin
               text_in  = BUF_W'(c);
               count_in = 4'd1;
               if (is_digit) begin
                  phase_in = PH_NUM;
               end else if (is_letter) begin
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_COLON;
               end
            end else begin
               push.b_valid = 1'b1;
            end
         end
      end

      push.a.last_of_run = !push.b_valid;
      push.b.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         text_ff  <= '0;
         count_ff <= 4'd0;
         ovf_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         text_ff  <= text_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

### rtl/kts_out_queue.sv
module kts_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  kts_pkg::push_type push,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kts_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = kts_pkg::OBUF_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);

   kts_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [1:0]       n_push;
   logic             pop;
   kts_pkg::rsp_type first;

   assign n_push = push_en ? ({1'b0, push.a_valid} + {1'b0, push.b_valid}) : 2'd0;
   assign first  = push.a_valid ? push.a : push.b;
   assign pop    = rsp_valid && rsp_ready;

   assign rsp_valid = level_ff != LW'(0);
   assign rsp_data  = entry_ff[rd_ff];
   // room for the worst case of two tokens from one transaction
   assign has_room  = level_ff <= LW'(DEPTH - 2);

   assign wr_in    = wr_ff + PW'(n_push);
   assign rd_in    = rd_ff + PW'(pop);
   assign level_in = level_ff + LW'(n_push) - LW'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ff + PW'(1)] <= push.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

### rtl/keyword_token_scanner.sv
// a token is registered into the result queue by the transaction that completes it, then leaves on rsp_
// throughput: one character per cycle while req_ready is high; a character may yield two tokens
// req_ready falls while the four-entry result queue has fewer than two free slots
// reset (synchronous) returns the automaton to its start state, clears the lexeme
// and empties the result queue
module keyword_token_scanner #(
   parameter int LEXEME_CHARS = kts_pkg::LEXEME_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kts_pkg::rsp_type rsp_data
);

   kts_pkg::push_type push;
   logic              advance;

   assign advance = req_valid && req_ready;

   kts_lexer #(
      .LEXEME_CHARS(LEXEME_CHARS)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_data),
      .push    (push)
   );

   kts_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (push),
      .has_room  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_eof_yields_token: assert property (@(posedge clock) disable iff (reset)
      advance && req_data.end_of_input |=> rsp_valid)
      else $error("end of input produced no token");

   a_eof_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == kts_pkg::KIND_ENDFILE |->
         rsp_data.lexeme_length == 4'd0 && !rsp_data.lexeme_truncated)
      else $error("end-of-file token carries a lexeme");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.lexeme_length <= 4'(LEXEME_CHARS))
      else $error("lexeme length beyond buffer");

   a_trunc_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lexeme_truncated |->
         rsp_data.lexeme_length == 4'(LEXEME_CHARS))
      else $error("truncated lexeme with buffer not full");
`endif

endmodule
